[hdl/battery_trimmed_mean_filter_macros.svh]
// Assertion macros used by the battery trimmed mean filter top level.
`ifndef BATTERY_TRIMMED_MEAN_FILTER_MACROS_SVH
`define BATTERY_TRIMMED_MEAN_FILTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BTMF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("btmf assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define BTMF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("btmf assertion failed");

`endif

[hdl/btmf_pkg.sv]
// Shared widths, reset values and register codes of the battery trimmed mean filter.
package btmf_pkg;

  localparam int SAMPLE_W = 12;
  localparam int SCALE_W  = 17;
  localparam int MV_W     = 13;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = SAMPLE_W + SCALE_W;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 17'd84030;

  // APB register map
  localparam int CFG_DATA_W = 32;
  localparam int PADDR_W    = 3;
  localparam logic REG_SCALE = 1'b0;

endpackage

[hdl/btmf_sample_if.sv]
// Input channel carrying one raw converter sample per request.
interface btmf_sample_if;
  logic                          valid;
  logic                          ready;
  logic [btmf_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

[hdl/btmf_result_if.sv]
// Output channel carrying one filtered millivolt value per request.
interface btmf_result_if;
  logic                      valid;
  logic                      ready;
  logic [btmf_pkg::MV_W-1:0] filtered_mv;

  modport source (output valid, output filtered_mv, input ready);
  modport sink (input valid, input filtered_mv, output ready);
endinterface

[hdl/btmf_ring_mem.sv]
// Window ring storage: one write port, one registered read port.
module btmf_ring_mem #(
  parameter int DEPTH = 15,
  parameter int WIDTH = 13
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/btmf_acc.sv]
// Shared scan unit: running sum, minimum and maximum over the window entries.
module btmf_acc #(
  parameter int WIDTH = 13,
  parameter int SUM_W = 17
) (
  input  logic             clk,
  input  logic             clear,
  input  logic             en,
  input  logic [WIDTH-1:0] data,
  output logic [SUM_W-1:0] sum,
  output logic [WIDTH-1:0] lo,
  output logic [WIDTH-1:0] hi
);

  // Clear before a scan, then fold in one entry a cycle while en is high
  always_ff @(posedge clk) begin
    if (clear) begin
      sum <= '0;
      lo  <= '1;
      hi  <= '0;
    end else if (en) begin
      sum <= sum + SUM_W'(data);
      if (data < lo) begin
        lo <= data;
      end
      if (data > hi) begin
        hi <= data;
      end
    end
  end

endmodule

[hdl/btmf_div.sv]
// Divider by a fixed divisor built on one reciprocal multiply.
module btmf_div #(
  parameter int DW      = 17,
  parameter int DIVISOR = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  output logic          done,
  output logic [DW-1:0] quotient
);

  // floor(n / DIVISOR) equals (n * RECIP) >> SHIFT for every n below 2**DW
  localparam int     SHIFT   = DW + $clog2(DIVISOR);
  localparam int     RECIP_W = DW + 1;
  localparam int     MUL_W   = DW + RECIP_W;
  localparam longint RECIP_L =
    ((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  logic [MUL_W-1:0] product;

  // Keep the integer part of the scaled product
  assign quotient = DW'(product >> SHIFT);

  // Pulse done the cycle after start
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // Multiply by the reciprocal on start
  always_ff @(posedge clk) begin
    if (start) begin
      product <= MUL_W'(dividend) * MUL_W'(RECIP);
    end
  end

endmodule

[hdl/battery_trimmed_mean_filter.sv]
// Top level of the battery voltage trimmed mean filter.
// Each sample request is scaled to millivolts as (sample * scale_q16) >> 16, written
// into a WINDOW-entry ring (the first sample after reset fills every entry), and
// answered by one result: the window sum less one minimum and one maximum, divided
// by WINDOW - 2 and truncated. The block takes one sample at a time. A sample goes
// through an accept step, a ring write, a scan of every window entry through the
// single ring read port, a step to fold in the last entry, a step to start the
// divide, the reciprocal multiply that divides by WINDOW - 2 and a step to hand
// over the result. The first sample after reset fills every ring entry in place
// of the single write.
// A finished result waits in an output register, so the next sample is taken while it
// is still pending; the block holds only when a second result is ready before the
// first one is taken. scale_q16 sits at APB byte address 0 and resets to 84030.
`include "battery_trimmed_mean_filter_macros.svh"

module battery_trimmed_mean_filter #(
  parameter int WINDOW = 15
) (
  input  logic                              clk,
  input  logic                              rst,
  btmf_sample_if.sink                       samples,
  btmf_result_if.source                     results,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [btmf_pkg::PADDR_W-1:0]      paddr,
  input  logic [btmf_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [btmf_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam int SUM_W = btmf_pkg::MV_W + $clog2(WINDOW);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_WRITE,
    S_SCAN,
    S_DRAIN,
    S_START,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;

  logic [btmf_pkg::SCALE_W-1:0] scale_q16;
  logic [btmf_pkg::PROD_W-1:0]  prod;
  logic [btmf_pkg::MV_W-1:0]    mv;
  logic [btmf_pkg::MV_W-1:0]    res;
  logic [btmf_pkg::MV_W-1:0]    out_mv;
  logic                         out_valid;
  logic                         out_load;
  logic                         primed;
  logic [IDX_W-1:0]             write_pos;
  logic [IDX_W-1:0]             idx;
  logic                         pend;
  logic                         accept;
  logic                         cfg_write;

  logic                         ring_we;
  logic [IDX_W-1:0]             ring_waddr;
  logic [btmf_pkg::MV_W-1:0]    ring_rdata;

  logic [SUM_W-1:0]             acc_sum;
  logic [btmf_pkg::MV_W-1:0]    acc_lo;
  logic [btmf_pkg::MV_W-1:0]    acc_hi;

  logic                         div_start;
  logic                         div_done;
  logic [SUM_W-1:0]             div_quo;
  logic [SUM_W-1:0]             trimmed;

  // APB register: scale_q16
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_q16 <= btmf_pkg::SCALE_RESET;
    end else if (cfg_write && (paddr[2] == btmf_pkg::REG_SCALE)) begin
      scale_q16 <= pwdata[btmf_pkg::SCALE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == btmf_pkg::REG_SCALE) begin
      prdata = btmf_pkg::CFG_DATA_W'(scale_q16);
    end
  end

  // Handshakes
  assign accept          = samples.valid && samples.ready;
  assign samples.ready   = (state == S_IDLE);
  assign results.valid   = out_valid;
  assign results.filtered_mv = out_mv;

  // Output register takes a new result once the previous one is gone
  assign out_load = (state == S_DONE) && (!out_valid || results.ready);

  // Scale the incoming sample to millivolts
  assign prod = btmf_pkg::PROD_W'(samples.sample) * btmf_pkg::PROD_W'(scale_q16);

  // Ring write port
  assign ring_we    = (state == S_FILL) || (state == S_WRITE);
  assign ring_waddr = (state == S_FILL) ? idx : write_pos;

  // Drop the extremes before dividing
  assign trimmed   = acc_sum - SUM_W'(acc_lo) - SUM_W'(acc_hi);
  assign div_start = (state == S_START);

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      primed    <= 1'b0;
      write_pos <= '0;
      idx       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Fold in the ring entry read during the scan
      pend <= (state == S_SCAN);
      // Load the output register or drop a taken result
      if (out_load) begin
        out_valid <= 1'b1;
        out_mv    <= res;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mv    <= prod[btmf_pkg::PROD_W-1:btmf_pkg::FRAC_W];
            idx   <= '0;
            state <= primed ? S_WRITE : S_FILL;
          end
        end
        S_FILL: begin
          if (idx == IDX_LAST) begin
            idx       <= '0;
            primed    <= 1'b1;
            write_pos <= '0;
            state     <= S_SCAN;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_WRITE: begin
          write_pos <= (write_pos == IDX_LAST) ? '0 : write_pos + IDX_W'(1);
          state     <= S_SCAN;
        end
        S_SCAN: begin
          if (idx == IDX_LAST) begin
            idx   <= '0;
            state <= S_DRAIN;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            res   <= div_quo[btmf_pkg::MV_W-1:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  btmf_ring_mem #(
    .DEPTH (WINDOW),
    .WIDTH (btmf_pkg::MV_W)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (mv),
    .raddr (idx),
    .rdata (ring_rdata)
  );

  btmf_acc #(
    .WIDTH (btmf_pkg::MV_W),
    .SUM_W (SUM_W)
  ) u_acc (
    .clk   (clk),
    .clear (accept),
    .en    (pend),
    .data  (ring_rdata),
    .sum   (acc_sum),
    .lo    (acc_lo),
    .hi    (acc_hi)
  );

  btmf_div #(
    .DW      (SUM_W),
    .DIVISOR (WINDOW - 2)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (trimmed),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Ring pointer never leaves the window
  `BTMF_ASSERT_IMP(a_wpos_range, 1'b1, write_pos <= IDX_LAST)
  // The first sample after reset fills the whole window
  `BTMF_ASSERT_NXT(a_first_fills, accept && !primed, state == S_FILL)
  // A divide finishes the cycle after it starts
  `BTMF_ASSERT_NXT(a_div_done, div_start, div_done)
  // A trimmed mean always fits the millivolt field
  `BTMF_ASSERT_IMP(a_quo_fits, div_done, div_quo[SUM_W-1:btmf_pkg::MV_W] == '0)
  // A finished result waits while the output register is still held
  `BTMF_ASSERT_NXT(a_done_waits, (state == S_DONE) && out_valid && !results.ready,
                   state == S_DONE)

endmodule
